FILE: sv/qss_pkg.sv
package qss_pkg;

  localparam int NumQueues = 8;
  localparam int TimeBits  = 32;
  // head wait never exceeds the 32-bit time fields
  localparam int WaitBits  = (TimeBits < 32) ? TimeBits : 32;

  localparam logic [2:0] ModeLongest    = 3'd0;
  localparam logic [2:0] ModeAvgWait    = 3'd1;
  localparam logic [2:0] ModeOldestHead = 3'd2;
  localparam logic [2:0] ModeRoundRobin = 3'd3;
  localparam logic [2:0] ModeStrict     = 3'd4;
  localparam logic [2:0] ModeShortest   = 3'd5;
  localparam logic [2:0] ModeAging      = 3'd6;

  localparam logic CfgPolicyMode     = 1'b0;
  localparam logic CfgAgingThreshold = 1'b1;

  typedef struct packed {
    logic [2:0]  queue_index;
    logic        queue_nonempty;
    logic [15:0] queue_length;
    logic [31:0] head_arrival;
    logic [31:0] average_wait;
    logic [31:0] now_time;
    logic        last_queue;
  } qss_in_t;

  typedef struct packed {
    logic       select_valid;
    logic [2:0] selected_queue;
  } qss_out_t;

endpackage

FILE: sv/queue_select_scheduler.sv
// Queue selection scheduler.
// Input channel (in_valid/in_stall/in_item): one item per queue status, a
// scan of items closed by an item with last_queue set. Output channel
// (out_valid/out_stall/out_item): one result per scan, the chosen queue or
// select_valid = 0 when every queue was empty.
// Config port (cfg_we/cfg_index/cfg_data): index 0 policy_mode, index 1
// aging_threshold; write only while no scan is in flight.
// Throughput: one item per cycle while the input register is not stalled. Each
// accepted item is held in the input register, then the compare-select
// registers absorb it; the result of a scan is registered in the output
// register as its last item leaves the input register.
// When the receiver stalls, the result holds; non-final items keep flowing,
// and only a final item waits in the input register until the result
// register frees up.
// Reset (rst, synchronous) clears the valid flags, config and scan state, sets the
// round robin pointer so the first round robin scan starts at queue 0.
module queue_select_scheduler (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  qss_pkg::qss_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output qss_pkg::qss_out_t out_item,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  logic [2:0]  policy_mode;
  logic [31:0] aging_threshold;

  qss_pkg::qss_in_t in_q;
  logic             in_q_valid;
  logic             advance;

  logic [2:0]  best_index,       best_index_next;
  logic [31:0] best_metric,      best_metric_next;
  logic        best_found,       best_found_next;
  logic [2:0]  aged_index,       aged_index_next;
  logic [31:0] aged_wait,        aged_wait_next;
  logic        aged_found,       aged_found_next;
  logic [2:0]  wrap_after_index, wrap_after_index_next;
  logic        wrap_after_found, wrap_after_found_next;
  logic [2:0]  last_served,      last_served_next;

  qss_pkg::qss_out_t res_next;

  logic [qss_pkg::WaitBits-1:0] now_t, arr_t;
  logic [31:0] wait_ticks, key;
  logic        item_ok, take;

  assign advance  = in_q_valid && !(in_q.last_queue && out_valid && out_stall);
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode     <= 3'd0;
      aging_threshold <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qss_pkg::CfgPolicyMode:     policy_mode     <= cfg_data[2:0];
        qss_pkg::CfgAgingThreshold: aging_threshold <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_item;
    end
  end

  always_comb begin
    now_t      = in_q.now_time[qss_pkg::WaitBits-1:0];
    arr_t      = in_q.head_arrival[qss_pkg::WaitBits-1:0];
    wait_ticks = (now_t >= arr_t) ? 32'(now_t - arr_t) : 32'd0;
    item_ok    = in_q.queue_nonempty &&
                 (32'(in_q.queue_index) < 32'(qss_pkg::NumQueues));

    unique case (policy_mode)
      qss_pkg::ModeAvgWait:    key = in_q.average_wait;
      qss_pkg::ModeOldestHead: key = wait_ticks;
      qss_pkg::ModeRoundRobin: key = 32'd0;
      qss_pkg::ModeStrict:     key = 32'd0;
      default:                 key = 32'(in_q.queue_length);
    endcase

    priority if (!best_found)              take = 1'b1;
    else if (key == best_metric)           take = in_q.queue_index < best_index;
    else if (policy_mode == qss_pkg::ModeShortest) take = key < best_metric;
    else                                   take = key > best_metric;

    best_index_next       = best_index;
    best_metric_next      = best_metric;
    best_found_next       = best_found;
    aged_index_next       = aged_index;
    aged_wait_next        = aged_wait;
    aged_found_next       = aged_found;
    wrap_after_index_next = wrap_after_index;
    wrap_after_found_next = wrap_after_found;
    last_served_next      = last_served;

    if (item_ok) begin
      if (take) begin
        best_found_next  = 1'b1;
        best_metric_next = key;
        best_index_next  = in_q.queue_index;
      end
      if (wait_ticks >= aging_threshold &&
          (!aged_found || wait_ticks > aged_wait ||
           (wait_ticks == aged_wait && in_q.queue_index < aged_index))) begin
        aged_found_next = 1'b1;
        aged_wait_next  = wait_ticks;
        aged_index_next = in_q.queue_index;
      end
      if (in_q.queue_index > last_served &&
          (!wrap_after_found || in_q.queue_index < wrap_after_index)) begin
        wrap_after_found_next = 1'b1;
        wrap_after_index_next = in_q.queue_index;
      end
    end

    // selection looks at the state including this item
    res_next.select_valid   = 1'b0;
    res_next.selected_queue = 3'd0;
    priority if (policy_mode == qss_pkg::ModeAging && aged_found_next) begin
      res_next.select_valid   = 1'b1;
      res_next.selected_queue = aged_index_next;
    end else if (policy_mode == qss_pkg::ModeRoundRobin) begin
      if (wrap_after_found_next) begin
        res_next.select_valid   = 1'b1;
        res_next.selected_queue = wrap_after_index_next;
      end else if (best_found_next) begin
        res_next.select_valid   = 1'b1;
        res_next.selected_queue = best_index_next;
      end
    end else begin
      res_next.select_valid   = best_found_next;
      res_next.selected_queue = best_found_next ? best_index_next : 3'd0;
    end

    if (in_q.last_queue) begin
      if (policy_mode == qss_pkg::ModeRoundRobin && res_next.select_valid) begin
        last_served_next = res_next.selected_queue;
      end
      best_index_next       = 3'd0;
      best_metric_next      = 32'd0;
      best_found_next       = 1'b0;
      aged_index_next       = 3'd0;
      aged_wait_next        = 32'd0;
      aged_found_next       = 1'b0;
      wrap_after_index_next = 3'd0;
      wrap_after_found_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_index       <= 3'd0;
      best_metric      <= 32'd0;
      best_found       <= 1'b0;
      aged_index       <= 3'd0;
      aged_wait        <= 32'd0;
      aged_found       <= 1'b0;
      wrap_after_index <= 3'd0;
      wrap_after_found <= 1'b0;
      last_served      <= 3'(qss_pkg::NumQueues - 1);
    end else if (advance) begin
      best_index       <= best_index_next;
      best_metric      <= best_metric_next;
      best_found       <= best_found_next;
      aged_index       <= aged_index_next;
      aged_wait        <= aged_wait_next;
      aged_found       <= aged_found_next;
      wrap_after_index <= wrap_after_index_next;
      wrap_after_found <= wrap_after_found_next;
      last_served      <= last_served_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_q.last_queue) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q.last_queue) begin
      out_item <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_sel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.select_valid |-> out_item.selected_queue == 3'd0)
    else $error("selected_queue nonzero without a selection");

  a_scan_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.last_queue |=> !best_found && !aged_found && !wrap_after_found)
    else $error("scan state not cleared after final item");

  a_rr_pointer: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.last_queue && policy_mode == qss_pkg::ModeRoundRobin &&
    res_next.select_valid |=> last_served == out_item.selected_queue)
    else $error("round robin pointer does not follow served queue");
`endif

endmodule
